### hw/rtl/stepper_phase_sequencer_top_assert.svh
// Assertion macros used by the stepper phase sequencer top level.
`ifndef STEPPER_PHASE_SEQUENCER_TOP_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define SPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sps: same-cycle check failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define SPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sps: next-cycle check failed");

`endif

### hw/rtl/sps_pkg.sv
// Shared types, constants and the phase table of the stepper phase sequencer.
package sps_pkg;

  localparam int COUNT_BITS  = 15;
  localparam int STEP_IN_W   = 15;
  localparam int TICK_W      = 16;
  localparam int PHASE_W     = 3;
  localparam int COIL_W      = 4;
  localparam int PHASE_NUM   = 6;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PHASE_NUM - 1);
  localparam logic [PHASE_W-1:0] NUM_PHASE  = PHASE_W'(PHASE_NUM);

  typedef enum logic [1:0] {
    REQ_NOP  = 2'd0,
    REQ_TICK = 2'd1,
    REQ_MOVE = 2'd2
  } req_kind_e;

  typedef struct packed {
    req_kind_e               kind;
    logic [COUNT_BITS-1:0]   count;
    logic                    dir;
    logic [TICK_W-1:0]       delay;
  } work_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // Coil pattern for each phase position, bit0 is the first line.
  function automatic logic [COIL_W-1:0] phase_coils(logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'h8;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

### hw/rtl/stepper_phase_sequencer_top.sv
// Top level of the stepper phase sequencer: front end, work queue and step engine.
//
//  channel | direction | payload                                       | handshake
//  in      | input     | req_type, step_count, direction, step_delay   | in_valid_i/in_ready_o
//  out     | output    | coil_drive, running, move_done, phase_index   | out_valid_o/out_ready_i
//
// One item per cycle sustained while the output is not stalled; an accepted item is first
// written into the two-entry queue, and the engine then loads its result into the result
// register as it pops the item from the queue.
// The step engine updates all counters and the phase table lookup together, at the edge that pops the item.
// Reset clears the motion state to idle with all coils low; no clearing pass is needed.
// A stalled output holds the engine; the queue absorbs up to two items before in_ready_o drops.
`include "stepper_phase_sequencer_top_assert.svh"

module stepper_phase_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [sps_pkg::STEP_IN_W-1:0] step_count_i,
  input  logic                          direction_i,
  input  logic [sps_pkg::TICK_W-1:0]    step_delay_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sps_pkg::COIL_W-1:0]    coil_drive_o,
  output logic                          running_o,
  output logic                          move_done_o,
  output logic [sps_pkg::PHASE_W-1:0]   phase_index_o
);
  import sps_pkg::*;

  fifo_stat_t fifo_stat;
  work_t      push_data;
  work_t      head;
  logic       push;
  logic       pop;

  // Classify incoming transactions
  sps_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .step_count_i (step_count_i),
    .direction_i  (direction_i),
    .step_delay_i (step_delay_i),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Decouple front and back
  sps_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  // Run the motion state
  sps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_stat_i   (fifo_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coil_drive_o  (coil_drive_o),
    .running_o     (running_o),
    .move_done_o   (move_done_o),
    .phase_index_o (phase_index_o)
  );

  // Checks
  `SPS_ASSERT_IMP(a_done_stops, out_valid_o && move_done_o, !running_o && coil_drive_o == '0)
  `SPS_ASSERT_IMP(a_idle_coils_low, !running_o, coil_drive_o == '0)
  `SPS_ASSERT_IMP(a_phase_range, 1'b1, phase_index_o <= LAST_PHASE)
  `SPS_ASSERT_NXT(a_push_lands, in_valid_i && in_ready_o, !fifo_stat.empty || out_valid_o)

endmodule

### hw/rtl/sps_front.sv
// Front end: takes input transactions, classifies them and pushes work to the queue.
module sps_front (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [sps_pkg::STEP_IN_W-1:0] step_count_i,
  input  logic                          direction_i,
  input  logic [sps_pkg::TICK_W-1:0]    step_delay_i,
  input  sps_pkg::fifo_stat_t           fifo_stat_i,
  output logic                          push_o,
  output sps_pkg::work_t                push_data_o
);
  import sps_pkg::*;

  logic [COUNT_BITS-1:0] count_masked;

  // Mask the step count to the counter width
  assign count_masked = COUNT_BITS'(step_count_i);

  // Accept whenever the queue has room
  assign in_ready_o = !fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

  // Classify: tick, real move, or move with zero count that is pushed as a no-op
  always_comb begin
    push_data_o.count = count_masked;
    push_data_o.dir   = direction_i;
    push_data_o.delay = step_delay_i;
    if (!req_type_i) begin
      push_data_o.kind = REQ_TICK;
    end else if (count_masked != '0) begin
      push_data_o.kind = REQ_MOVE;
    end else begin
      push_data_o.kind = REQ_NOP;
    end
  end

endmodule

### hw/rtl/sps_fifo.sv
// Short work queue between the front end and the step engine.
module sps_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sps_pkg::work_t      push_data_i,
  input  logic                pop_i,
  output sps_pkg::work_t      head_o,
  output sps_pkg::fifo_stat_t stat_o
);
  import sps_pkg::*;

  work_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  // Status toward both sides
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_o       = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed work
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/sps_back.sv
// Step engine: runs queued work against the motion state and holds the result.
module sps_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sps_pkg::work_t              head_i,
  input  sps_pkg::fifo_stat_t         fifo_stat_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sps_pkg::COIL_W-1:0]  coil_drive_o,
  output logic                        running_o,
  output logic                        move_done_o,
  output logic [sps_pkg::PHASE_W-1:0] phase_index_o
);
  import sps_pkg::*;

  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [TICK_W-1:0]     tick_q, tick_d;
  logic [COUNT_BITS-1:0] done_cnt_q, done_cnt_d;
  logic [COUNT_BITS-1:0] target_q, target_d;
  logic                  dir_q, dir_d;
  logic [TICK_W-1:0]     delay_q, delay_d;
  logic                  active_q, active_d;
  logic [COIL_W-1:0]     coil_q, coil_d;
  logic                  out_valid_q, out_valid_d;
  logic                  done_q, done_d;

  logic [TICK_W-1:0]     tick_inc;
  logic [COUNT_BITS-1:0] done_inc;
  logic [PHASE_W-1:0]    phase_next;
  logic                  step_hit;
  logic                  finish;

  // Take the next work item when the result slot is free or being drained
  assign pop_o = !fifo_stat_i.empty && (!out_valid_q || out_ready_i);

  // Step arithmetic
  assign tick_inc = tick_q + 1'b1;
  assign step_hit = (tick_inc >= delay_q);
  assign done_inc = done_cnt_q + 1'b1;
  assign finish   = (done_inc >= target_q);

  always_comb begin
    if (!dir_q) begin
      phase_next = (phase_q >= LAST_PHASE) ? '0 : phase_q + 1'b1;
    end else begin
      phase_next = (phase_q == '0 || phase_q >= NUM_PHASE) ? LAST_PHASE : phase_q - 1'b1;
    end
  end

  // Apply one work item to the motion state
  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    done_cnt_d  = done_cnt_q;
    target_d    = target_q;
    dir_d       = dir_q;
    delay_d     = delay_q;
    active_d    = active_q;
    coil_d      = coil_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      out_valid_d = 1'b1;
      done_d      = 1'b0;
      case (head_i.kind)
        REQ_MOVE: begin
          target_d = head_i.count;
          dir_d    = head_i.dir;
          delay_d  = head_i.delay;
          active_d = 1'b1;
        end
        REQ_TICK: begin
          if (active_q) begin
            tick_d = step_hit ? '0 : tick_inc;
            if (step_hit) begin
              phase_d = phase_next;
              if (finish) begin
                active_d   = 1'b0;
                done_cnt_d = '0;
                target_d   = '0;
                coil_d     = '0;
                done_d     = 1'b1;
              end else begin
                done_cnt_d = done_inc;
                coil_d     = phase_coils(phase_next);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      tick_q      <= '0;
      done_cnt_q  <= '0;
      target_q    <= '0;
      dir_q       <= 1'b0;
      delay_q     <= '0;
      active_q    <= 1'b0;
      coil_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      done_cnt_q  <= done_cnt_d;
      target_q    <= target_d;
      dir_q       <= dir_d;
      delay_q     <= delay_d;
      active_q    <= active_d;
      coil_q      <= coil_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result shows the state left by the last item
  assign out_valid_o   = out_valid_q;
  assign coil_drive_o  = coil_q;
  assign running_o     = active_q;
  assign move_done_o   = done_q;
  assign phase_index_o = phase_q;

endmodule

### sim/stepper_phase_sequencer_top_test.sv
// Self-checking testbench of the stepper phase sequencer: predicts every coil state and compares.
module stepper_phase_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam logic REQ_TYPE_TICK = 1'b0;
  localparam logic REQ_TYPE_MOVE = 1'b1;
  localparam logic DIR_FWD       = 1'b0;
  localparam logic DIR_REV       = 1'b1;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int QUIET_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int DIRECTED_ROWS  = 22;

  // Coil pattern per phase position, bit0 is the first line
  localparam logic [COIL_W-1:0] COIL_PATTERN [PHASE_NUM] =
    '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'h8};

  typedef struct packed {
    logic                 req_type;
    logic [STEP_IN_W-1:0] step_count;
    logic                 direction;
    logic [TICK_W-1:0]    step_delay;
  } motor_req_t;

  typedef struct packed {
    logic [COIL_W-1:0]  coil_drive;
    logic               running;
    logic               move_done;
    logic [PHASE_W-1:0] phase_index;
  } motor_out_t;

  typedef struct packed {
    motor_req_t req;
    logic       typed;
    motor_out_t exp;
  } directed_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 req_type_i = REQ_TYPE_TICK;
  logic [STEP_IN_W-1:0] step_count_i = '0;
  logic                 direction_i = DIR_FWD;
  logic [TICK_W-1:0]    step_delay_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [COIL_W-1:0]    coil_drive_o;
  logic                 running_o;
  logic                 move_done_o;
  logic [PHASE_W-1:0]   phase_index_o;

  // Motor state as seen by the predictor
  logic [PHASE_W-1:0]    pos_phase;
  logic [TICK_W-1:0]     tick_cnt;
  logic [COUNT_BITS-1:0] steps_made;
  logic [COUNT_BITS-1:0] steps_goal;
  logic                  goal_dir;
  logic [TICK_W-1:0]     goal_delay;
  logic                  moving;
  logic [COIL_W-1:0]     coils_now;

  motor_out_t pending_outputs [$];
  int         mismatch_cnt = 0;
  int         items_sent = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  logic       hold_request = 1'b0;

  // Directed stimulus; expected outputs typed in only where obvious
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{REQ_TYPE_TICK, 15'h7fff, DIR_REV, 16'hffff}, 1'b1, '{4'h0, 1'b0, 1'b0, 3'd0}},
    '{'{REQ_TYPE_MOVE, 15'h0000, DIR_REV, 16'h0005}, 1'b1, '{4'h0, 1'b0, 1'b0, 3'd0}},
    '{'{REQ_TYPE_MOVE, 15'h0001, DIR_FWD, 16'h0000}, 1'b1, '{4'h0, 1'b1, 1'b0, 3'd0}},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b1, '{4'h0, 1'b0, 1'b1, 3'd1}},
    '{'{REQ_TYPE_MOVE, 15'h0003, DIR_REV, 16'h0001}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h7fff, DIR_FWD, 16'hffff}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_REV, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_MOVE, 15'h7fff, DIR_FWD, 16'hffff}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_MOVE, 15'h0002, DIR_REV, 16'h0002}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_MOVE, 15'h0001, DIR_FWD, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h5555, DIR_REV, 16'haaaa}, 1'b0, '0},
    '{'{REQ_TYPE_MOVE, 15'h4000, DIR_FWD, 16'h0001}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_MOVE, 15'h0001, DIR_REV, 16'h0000}, 1'b0, '0},
    '{'{REQ_TYPE_TICK, 15'h0000, DIR_FWD, 16'h0000}, 1'b0, '0}
  };

  stepper_phase_sequencer_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .step_count_i (step_count_i),
    .direction_i  (direction_i),
    .step_delay_i (step_delay_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .coil_drive_o (coil_drive_o),
    .running_o    (running_o),
    .move_done_o  (move_done_o),
    .phase_index_o(phase_index_o)
  );

  // Generate the clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance the motor state by one transaction and return the coil state it leaves
  function automatic motor_out_t step_motor(motor_req_t req);
    motor_out_t res;
    logic       finished;
    finished = 1'b0;
    if (req.req_type == REQ_TYPE_MOVE) begin
      if (req.step_count[COUNT_BITS-1:0] != '0) begin
        steps_goal = req.step_count[COUNT_BITS-1:0];
        goal_dir   = req.direction;
        goal_delay = req.step_delay;
        moving     = 1'b1;
      end
    end else if (moving) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= goal_delay) begin
        tick_cnt = '0;
        if (goal_dir == DIR_FWD) begin
          pos_phase = (pos_phase == LAST_PHASE) ? '0 : pos_phase + 1'b1;
        end else begin
          pos_phase = (pos_phase == '0) ? LAST_PHASE : pos_phase - 1'b1;
        end
        coils_now  = COIL_PATTERN[pos_phase];
        steps_made = steps_made + 1'b1;
        // Stop once the goal is reached: clear counts and drop all coils
        if (steps_made >= steps_goal) begin
          moving     = 1'b0;
          steps_made = '0;
          steps_goal = '0;
          coils_now  = '0;
          finished   = 1'b1;
        end
      end
    end
    res.coil_drive  = coils_now;
    res.running     = moving;
    res.move_done   = finished;
    res.phase_index = pos_phase;
    return res;
  endfunction

  // Offer one transaction, wait for acceptance and queue its expected output
  task automatic offer_request(input motor_req_t req, input logic typed,
                               input motor_out_t typed_out);
    motor_out_t predicted;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req.req_type;
    step_count_i <= req.step_count;
    direction_i  <= req.direction;
    step_delay_i <= req.step_delay;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = step_motor(req);
    pending_outputs.push_back(typed ? typed_out : predicted);
    items_sent++;
  endtask

  // Tick with random content in the fields a tick ignores
  function automatic motor_req_t rand_tick();
    motor_req_t req;
    req.req_type   = REQ_TYPE_TICK;
    req.step_count = STEP_IN_W'($urandom);
    req.direction  = 1'($urandom);
    req.step_delay = TICK_W'($urandom);
    return req;
  endfunction

  // Issue a move followed by enough ticks to usually finish it
  task automatic offer_move_sequence();
    motor_req_t req;
    int         roll;
    int         span;
    int         ticks;
    req.req_type  = REQ_TYPE_MOVE;
    req.direction = 1'($urandom);
    roll = $urandom_range(99);
    if (roll < 90) req.step_count = STEP_IN_W'($urandom_range(1, 6));
    else req.step_count = STEP_IN_W'($urandom_range(1, 32767));
    roll = $urandom_range(99);
    if (roll < 60) req.step_delay = TICK_W'($urandom_range(0, 3));
    else if (roll < 90) req.step_delay = TICK_W'($urandom_range(4, 12));
    else req.step_delay = TICK_W'($urandom);
    offer_request(req, 1'b0, '0);
    span = int'(req.step_count) * (int'(req.step_delay) + 1) + 2;
    if (span > 60) span = 60;
    ticks = $urandom_range(1, span);
    repeat (ticks) offer_request(rand_tick(), 1'b0, '0);
  endtask

  // Stall the output side at random, or hold it off for a long stretch on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin
    motor_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("unexpected output: coil=%h run=%b done=%b phase=%0d",
                   coil_drive_o, running_o, move_done_o, phase_index_o);
        mismatch_cnt++;
      end else begin
        want = pending_outputs.pop_front();
        if (coil_drive_o !== want.coil_drive || running_o !== want.running ||
            move_done_o !== want.move_done || phase_index_o !== want.phase_index) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("mismatch: expected coil=%h run=%b done=%b phase=%0d, got coil=%h run=%b done=%b phase=%0d",
                     want.coil_drive, want.running, want.move_done, want.phase_index,
                     coil_drive_o, running_o, move_done_o, phase_index_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL stepper_phase_sequencer_top");
      $finish;
    end
  end

  initial begin
    motor_req_t req;
    int         rand_start;
    int         done_rand;
    logic       drained_once;
    logic       held_once;
    drained_once = 1'b0;
    held_once    = 1'b0;
    pos_phase    = '0;
    tick_cnt     = '0;
    steps_made   = '0;
    steps_goal   = '0;
    goal_dir     = DIR_FWD;
    goal_delay   = '0;
    moving       = 1'b0;
    coils_now    = '0;

    // Hold reset, then release it on a clock edge
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < DIRECTED_ROWS; i++)
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].exp);

    // Random part: mostly complete moves, some noise; idling changes by quarter
    rand_start = items_sent;
    done_rand  = 0;
    while (done_rand < RANDOM_ITEMS) begin
      case (done_rand * 4 / RANDOM_ITEMS)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
      endcase
      // Pause the input until every queued output has come back
      if (!drained_once && done_rand >= RANDOM_ITEMS / 8) begin
        drained_once = 1'b1;
        in_valid_i <= 1'b0;
        wait (pending_outputs.size() == 0);
        @(posedge clk_i);
      end
      // Hold off the output while input keeps coming, so the block backs up
      if (!held_once && done_rand >= RANDOM_ITEMS / 2) begin
        held_once    = 1'b1;
        hold_request = 1'b1;
      end
      if ($urandom_range(99) < 75) begin
        offer_move_sequence();
      end else begin
        req.req_type   = 1'($urandom);
        req.step_count = ($urandom_range(99) < 20) ? '0 : STEP_IN_W'($urandom);
        req.direction  = 1'($urandom);
        req.step_delay = TICK_W'($urandom);
        offer_request(req, 1'b0, '0);
      end
      done_rand = items_sent - rand_start;
    end

    // Drain and settle
    in_valid_i <= 1'b0;
    wait (pending_outputs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS stepper_phase_sequencer_top");
    end else begin
      $display("FAIL stepper_phase_sequencer_top");
    end
    $finish;
  end

endmodule
